[rtl/core/sparse_csr_transpose_assert.svh]
// ----------------------------------------------------------------------------
// sparse csr transpose assertion macros
// shared property forms for the checker, clocked on clk, off during reset
// ----------------------------------------------------------------------------
`ifndef SPARSE_CSR_TRANSPOSE_ASSERT_SVH
`define SPARSE_CSR_TRANSPOSE_ASSERT_SVH

// same-cycle implication
`define CSRT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSRT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/csr_tp_pkg.sv]
// ----------------------------------------------------------------------------
// csr transpose package
// field widths, op and status codes and register indexes of the engine
// ----------------------------------------------------------------------------
`default_nettype none

package csr_tp_pkg;

  // input fields
  localparam int OP_W     = 3;
  localparam int SLOT_W   = 13;
  localparam int RSTART_W = 13;
  localparam int COL_W    = 10;

  localparam int SLOT_LSB   = 0;
  localparam int RSTART_LSB = SLOT_LSB + SLOT_W;
  localparam int COL_LSB    = RSTART_LSB + RSTART_W;
  localparam int VAL_LSB    = COL_LSB + COL_W;

  // result fields
  localparam int POS_W = 13;
  localparam int ST_W  = 2;

  // column counters wrap at this width
  localparam int CNT_W = 13;

  // configuration
  localparam int NROWS_W = 11;
  localparam int NCOLS_W = 11;
  localparam int NNZ_W   = 13;
  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [1:0] REG_NUM_ROWS = 2'd0;
  localparam logic [1:0] REG_NUM_COLS = 2'd1;
  localparam logic [1:0] REG_NUM_NNZ  = 2'd2;

  // op codes
  localparam logic [OP_W-1:0] OP_LOAD_ROW   = 3'd0;
  localparam logic [OP_W-1:0] OP_LOAD_ENTRY = 3'd1;
  localparam logic [OP_W-1:0] OP_RUN        = 3'd2;
  localparam logic [OP_W-1:0] OP_RD_COL     = 3'd3;
  localparam logic [OP_W-1:0] OP_RD_ENTRY   = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_DONE = 2'd1;
  localparam logic [ST_W-1:0] ST_BAD  = 2'd2;

endpackage

`default_nettype wire

[rtl/core/sparse_csr_transpose.sv]
// ----------------------------------------------------------------------------
// sparse csr transpose
// compressed-row to compressed-column transpose by counting sort
// ----------------------------------------------------------------------------
// usage:
// - in_* stream: in_tuser carries the op, in_tdata the slot, row start, column
//   and value; loads (ops 0, 1) give no result, a run (op 2) and reads
//   (ops 3, 4) give one transaction on the out_* stream
// - out_tdata carries position and entry value, out_tuser the status
// - cfg_* apb port holds num_rows, num_columns, num_nonzeros at 0x0, 0x4, 0x8;
//   write it only while the engine is idle
// - loads may come back to back while the sequencer is idle; a read goes
//   through the synchronous memory read, then fills the output register
// - a run holds in_tready low until its done result enters the output
//   register: a clear sweep, then count, prefix, scatter and shift passes,
//   each a read-modify-write on the counter memory
// - reset clears the control state and the result-ready flag; the memories
//   are not swept, reads answer status 2 until the first run is done
// - while out_tready is low the result register holds; loads still go in,
//   reads and the end of a run wait for the register to drain
// ----------------------------------------------------------------------------
`default_nettype none

module sparse_csr_transpose
  import csr_tp_pkg::*;
#(
  parameter int MAX_ROWS     = 1024,
  parameter int MAX_COLUMNS  = 1024,
  parameter int MAX_NONZEROS = 4096,
  parameter int VALUE_WIDTH  = 32,
  localparam int IN_DW  = ((VAL_LSB + VALUE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DW = ((POS_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // input stream
  input  wire logic                in_tvalid,
  output logic                     in_tready,
  input  wire logic [IN_DW-1:0]    in_tdata,   // slot, row_start, column, value
  input  wire logic [OP_W-1:0]     in_tuser,   // op
  // result stream
  output logic                     out_tvalid,
  input  wire logic                out_tready,
  output logic [OUT_DW-1:0]        out_tdata,  // position, entry_value
  output logic [ST_W-1:0]          out_tuser,  // status
  // configuration
  input  wire logic                cfg_psel,
  input  wire logic                cfg_penable,
  input  wire logic                cfg_pwrite,
  input  wire logic [CFG_AW-1:0]   cfg_paddr,
  input  wire logic [CFG_DW-1:0]   cfg_pwdata,
  output logic [CFG_DW-1:0]        cfg_prdata,
  output logic                     cfg_pready
);

  // address and count widths
  localparam int RSA  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;       // row start addr
  localparam int SAW  = (MAX_NONZEROS > 1) ? $clog2(MAX_NONZEROS) : 1; // entry addr
  localparam int CNA  = $clog2(MAX_COLUMNS + 1);                     // counter addr
  localparam int RCW  = $clog2(MAX_ROWS + 1);                        // row count
  localparam int NCW  = $clog2(MAX_NONZEROS + 1);                    // nonzero count
  localparam int IMAX = (MAX_NONZEROS > MAX_COLUMNS + 1) ? MAX_NONZEROS : MAX_COLUMNS + 1;
  localparam int IW   = $clog2(IMAX + 1);                            // sweep index

  typedef struct packed {
    logic [COL_W-1:0]       col;
    logic [VALUE_WIDTH-1:0] val;
  } src_ent_t;

  typedef struct packed {
    logic [RSA-1:0]         row;
    logic [VALUE_WIDTH-1:0] val;
  } res_ent_t;

  // sequencer states, one-hot
  typedef enum logic [15:0] {
    S_IDLE    = 16'h0001,
    S_CLEAR   = 16'h0002,
    S_CNT_RD  = 16'h0004,
    S_CNT_COL = 16'h0008,
    S_CNT_WR  = 16'h0010,
    S_PRE_RD  = 16'h0020,
    S_PRE_WR  = 16'h0040,
    S_ROW_LO  = 16'h0080,
    S_ROW_HI  = 16'h0100,
    S_ROW_SET = 16'h0200,
    S_SC_RD   = 16'h0400,
    S_SC_COL  = 16'h0800,
    S_SC_WR   = 16'h1000,
    S_SH_RD   = 16'h2000,
    S_SH_WR   = 16'h4000,
    S_FIN     = 16'h8000
  } state_t;

  // --------------------------------------------------------------------------
  // input field unpacking
  // --------------------------------------------------------------------------
  logic [SLOT_W-1:0]      in_slot;
  logic [RSTART_W-1:0]    in_rstart;
  logic [COL_W-1:0]       in_col;
  logic [VALUE_WIDTH-1:0] in_val;
  logic                   in_is_rd;
  logic                   in_acc;

  assign in_slot   = in_tdata[SLOT_LSB +: SLOT_W];
  assign in_rstart = in_tdata[RSTART_LSB +: RSTART_W];
  assign in_col    = in_tdata[COL_LSB +: COL_W];
  assign in_val    = in_tdata[VAL_LSB +: VALUE_WIDTH];
  assign in_is_rd  = (in_tuser == OP_RD_COL) || (in_tuser == OP_RD_ENTRY);

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  state_t               state_r, state_nxt;
  logic [IW-1:0]        idx_r, idx_nxt;     // entry or column sweep index
  logic [RCW-1:0]       row_r, row_nxt;     // scatter row
  logic [IW-1:0]        hi_r, hi_nxt;       // end of the current row
  logic [CNT_W-1:0]     acc_r, acc_nxt;     // running prefix sum
  logic [RCW-1:0]       run_rows_r, run_rows_nxt;
  logic [CNA-1:0]       run_cols_r, run_cols_nxt;
  logic [NCW-1:0]       run_nnz_r, run_nnz_nxt;
  logic                 ready_r, ready_nxt; // a run has finished
  logic                 pend_r, pend_nxt;   // read data lands next cycle
  logic                 pend_ent_r, pend_ent_nxt;
  logic                 pend_ok_r, pend_ok_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic [POS_W-1:0]       out_pos_r, out_pos_nxt;
  logic [VALUE_WIDTH-1:0] out_val_r, out_val_nxt;
  logic [ST_W-1:0]        out_st_r, out_st_nxt;

  logic [NROWS_W-1:0] num_rows_r;
  logic [NCOLS_W-1:0] num_cols_r;
  logic [NNZ_W-1:0]   num_nnz_r;

  // --------------------------------------------------------------------------
  // memories: one write port, one registered read port each
  // --------------------------------------------------------------------------
  logic [RSTART_W-1:0] rs_mem [MAX_ROWS];
  src_ent_t            src_mem [MAX_NONZEROS];
  logic [CNT_W-1:0]    cnt_mem [MAX_COLUMNS + 1];
  res_ent_t            res_mem [MAX_NONZEROS];

  logic                rs_we, rs_re;
  logic [RSA-1:0]      rs_wa, rs_ra;
  logic [RSTART_W-1:0] rs_wd, rs_rdata_r;

  logic                src_we, src_re;
  logic [SAW-1:0]      src_wa, src_ra;
  src_ent_t            src_wd, src_rdata_r;

  logic                cnt_we, cnt_re;
  logic [CNA-1:0]      cnt_wa, cnt_ra;
  logic [CNT_W-1:0]    cnt_wd, cnt_rdata_r;

  logic                res_we, res_re;
  logic [SAW-1:0]      res_wa, res_ra;
  res_ent_t            res_wd, res_rdata_r;

  always_ff @(posedge clk) begin
    if (rs_we) rs_mem[rs_wa] <= rs_wd;
    if (rs_re) rs_rdata_r <= rs_mem[rs_ra];
  end

  always_ff @(posedge clk) begin
    if (src_we) src_mem[src_wa] <= src_wd;
    if (src_re) src_rdata_r <= src_mem[src_ra];
  end

  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    if (cnt_re) cnt_rdata_r <= cnt_mem[cnt_ra];
  end

  always_ff @(posedge clk) begin
    if (res_we) res_mem[res_wa] <= res_wd;
    if (res_re) res_rdata_r <= res_mem[res_ra];
  end

  // --------------------------------------------------------------------------
  // handshake
  // --------------------------------------------------------------------------
  // loads and runs only need the sequencer idle; reads also need no read in
  // flight and the output register free by the time their data lands
  assign in_tready = (state_r == S_IDLE) &&
                     (!in_is_rd || (!pend_r && (!out_valid_r || out_tready)));
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_DW'({out_val_r, out_pos_r});
  assign out_tuser  = out_st_r;

  // --------------------------------------------------------------------------
  // sequencer datapath helpers
  // --------------------------------------------------------------------------
  logic          col_ok;      // fetched source column is in range
  logic [IW-1:0] rs_sat;      // fetched row start clamped to the nonzero count
  logic          row_last;
  logic          clr_last;
  logic          fin_go;

  assign col_ok   = 32'(src_rdata_r.col) < 32'(run_cols_r);
  assign rs_sat   = (32'(rs_rdata_r) > 32'(run_nnz_r)) ? IW'(run_nnz_r) : IW'(rs_rdata_r);
  assign row_last = (32'(row_r) + 32'd1) >= 32'(run_rows_r);
  assign clr_last = ((32'(idx_r) + 32'd1) >= 32'(run_nnz_r)) &&
                    (32'(idx_r) >= 32'(run_cols_r));
  assign fin_go   = !out_valid_r || out_tready;

  always_comb begin
    state_nxt    = state_r;
    idx_nxt      = idx_r;
    row_nxt      = row_r;
    hi_nxt       = hi_r;
    acc_nxt      = acc_r;
    run_rows_nxt = run_rows_r;
    run_cols_nxt = run_cols_r;
    run_nnz_nxt  = run_nnz_r;
    ready_nxt    = ready_r;
    pend_nxt     = 1'b0;
    pend_ent_nxt = pend_ent_r;
    pend_ok_nxt  = pend_ok_r;

    rs_we  = 1'b0;
    rs_wa  = RSA'(in_slot);
    rs_wd  = in_rstart;
    rs_re  = 1'b0;
    rs_ra  = RSA'(row_r);

    src_we     = 1'b0;
    src_wa     = SAW'(in_slot);
    src_wd.col = in_col;
    src_wd.val = in_val;
    src_re     = 1'b0;
    src_ra     = SAW'(idx_r);

    cnt_we = 1'b0;
    cnt_wa = CNA'(idx_r);
    cnt_wd = '0;
    cnt_re = 1'b0;
    cnt_ra = CNA'(idx_r);

    res_we     = 1'b0;
    res_wa     = SAW'(idx_r);
    res_wd.row = '0;
    res_wd.val = '0;
    res_re     = 1'b0;
    res_ra     = SAW'(in_slot);

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          priority if (in_tuser == OP_LOAD_ROW) begin
            rs_we = 32'(in_slot) < MAX_ROWS;
          end else if (in_tuser == OP_LOAD_ENTRY) begin
            src_we = 32'(in_slot) < MAX_NONZEROS;
          end else if (in_tuser == OP_RUN) begin
            // clamp the configured sizes to the store depths
            run_rows_nxt = (32'(num_rows_r) > MAX_ROWS) ? RCW'(MAX_ROWS)
                                                         : RCW'(num_rows_r);
            run_cols_nxt = (32'(num_cols_r) > MAX_COLUMNS) ? CNA'(MAX_COLUMNS)
                                                            : CNA'(num_cols_r);
            run_nnz_nxt  = (32'(num_nnz_r) > MAX_NONZEROS) ? NCW'(MAX_NONZEROS)
                                                            : NCW'(num_nnz_r);
            idx_nxt      = '0;
            state_nxt    = S_CLEAR;
          end else if (in_tuser == OP_RD_COL) begin
            pend_nxt     = 1'b1;
            pend_ent_nxt = 1'b0;
            pend_ok_nxt  = ready_r && (32'(in_slot) <= 32'(run_cols_r));
            cnt_re       = 1'b1;
            cnt_ra       = CNA'(in_slot);
          end else if (in_tuser == OP_RD_ENTRY) begin
            pend_nxt     = 1'b1;
            pend_ent_nxt = 1'b1;
            pend_ok_nxt  = ready_r && (32'(in_slot) < 32'(run_nnz_r));
            res_re       = 1'b1;
          end else begin
            // unknown op, dropped
          end
        end
      end

      // zero counters 0..C and result slots 0..N-1 in one sweep
      S_CLEAR: begin
        cnt_we = 32'(idx_r) <= 32'(run_cols_r);
        res_we = 32'(idx_r) < 32'(run_nnz_r);
        if (clr_last) begin
          idx_nxt   = '0;
          state_nxt = S_CNT_RD;
        end else begin
          idx_nxt = idx_r + IW'(1);
        end
      end

      // count pass: counter[c+1] += 1 for each entry in range
      S_CNT_RD: begin
        if (32'(idx_r) >= 32'(run_nnz_r)) begin
          idx_nxt   = IW'(1);
          acc_nxt   = '0;
          state_nxt = S_PRE_RD;
        end else begin
          src_re    = 1'b1;
          state_nxt = S_CNT_COL;
        end
      end

      S_CNT_COL: begin
        if (col_ok) begin
          cnt_re    = 1'b1;
          cnt_ra    = CNA'(32'(src_rdata_r.col) + 32'd1);
          state_nxt = S_CNT_WR;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_CNT_RD;
        end
      end

      S_CNT_WR: begin
        cnt_we    = 1'b1;
        cnt_wa    = CNA'(32'(src_rdata_r.col) + 32'd1);
        cnt_wd    = cnt_rdata_r + CNT_W'(1);
        idx_nxt   = idx_r + IW'(1);
        state_nxt = S_CNT_RD;
      end

      // prefix pass over columns 1..C-1, counter[0] is zero after the clear
      S_PRE_RD: begin
        if (32'(idx_r) >= 32'(run_cols_r)) begin
          row_nxt   = '0;
          state_nxt = S_ROW_LO;
        end else begin
          cnt_re    = 1'b1;
          state_nxt = S_PRE_WR;
        end
      end

      S_PRE_WR: begin
        cnt_we    = 1'b1;
        cnt_wd    = cnt_rdata_r + acc_r;
        acc_nxt   = cnt_rdata_r + acc_r;
        idx_nxt   = idx_r + IW'(1);
        state_nxt = S_PRE_RD;
      end

      // scatter pass, one row at a time
      S_ROW_LO: begin
        if (32'(row_r) >= 32'(run_rows_r)) begin
          idx_nxt   = IW'(run_cols_r);
          state_nxt = S_SH_RD;
        end else begin
          rs_re     = 1'b1;
          state_nxt = S_ROW_HI;
        end
      end

      S_ROW_HI: begin
        idx_nxt   = rs_sat;
        rs_re     = !row_last;
        rs_ra     = RSA'(32'(row_r) + 32'd1);
        state_nxt = S_ROW_SET;
      end

      S_ROW_SET: begin
        // the last row ends at the nonzero count
        hi_nxt    = row_last ? IW'(run_nnz_r) : rs_sat;
        state_nxt = S_SC_RD;
      end

      S_SC_RD: begin
        if (32'(idx_r) >= 32'(hi_r)) begin
          row_nxt   = row_r + RCW'(1);
          state_nxt = S_ROW_LO;
        end else begin
          src_re    = 1'b1;
          state_nxt = S_SC_COL;
        end
      end

      S_SC_COL: begin
        if (col_ok) begin
          cnt_re    = 1'b1;
          cnt_ra    = CNA'(src_rdata_r.col);
          state_nxt = S_SC_WR;
        end else begin
          idx_nxt   = idx_r + IW'(1);
          state_nxt = S_SC_RD;
        end
      end

      S_SC_WR: begin
        // slot beyond the nonzero count is dropped, the counter still moves
        res_we     = 32'(cnt_rdata_r) < 32'(run_nnz_r);
        res_wa     = SAW'(cnt_rdata_r);
        res_wd.row = RSA'(row_r);
        res_wd.val = src_rdata_r.val;
        cnt_we     = 1'b1;
        cnt_wa     = CNA'(src_rdata_r.col);
        cnt_wd     = cnt_rdata_r + CNT_W'(1);
        idx_nxt    = idx_r + IW'(1);
        state_nxt  = S_SC_RD;
      end

      // shift pass: counter[c] = counter[c-1] from C down to 1, then counter[0] = 0
      S_SH_RD: begin
        if (idx_r == '0) begin
          cnt_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          cnt_re    = 1'b1;
          cnt_ra    = CNA'(32'(idx_r) - 32'd1);
          state_nxt = S_SH_WR;
        end
      end

      S_SH_WR: begin
        cnt_we    = 1'b1;
        cnt_wd    = cnt_rdata_r;
        idx_nxt   = idx_r - IW'(1);
        state_nxt = S_SH_RD;
      end

      S_FIN: begin
        if (fin_go) begin
          ready_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_val_nxt   = out_val_r;
    out_st_nxt    = out_st_r;
    priority if (pend_r) begin
      // read data from the previous cycle, zero fields when rejected
      out_valid_nxt = 1'b1;
      out_st_nxt    = pend_ok_r ? ST_OK : ST_BAD;
      if (!pend_ok_r) begin
        out_pos_nxt = '0;
        out_val_nxt = '0;
      end else if (pend_ent_r) begin
        out_pos_nxt = POS_W'(res_rdata_r.row);
        out_val_nxt = res_rdata_r.val;
      end else begin
        out_pos_nxt = cnt_rdata_r;
        out_val_nxt = '0;
      end
    end else if ((state_r == S_FIN) && fin_go) begin
      out_valid_nxt = 1'b1;
      out_pos_nxt   = '0;
      out_val_nxt   = '0;
      out_st_nxt    = ST_DONE;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ready_r     <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      run_rows_r  <= '0;
      run_cols_r  <= '0;
      run_nnz_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      ready_r     <= ready_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      run_rows_r  <= run_rows_nxt;
      run_cols_r  <= run_cols_nxt;
      run_nnz_r   <= run_nnz_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    row_r      <= row_nxt;
    hi_r       <= hi_nxt;
    acc_r      <= acc_nxt;
    pend_ent_r <= pend_ent_nxt;
    pend_ok_r  <= pend_ok_nxt;
    out_pos_r  <= out_pos_nxt;
    out_val_r  <= out_val_nxt;
    out_st_r   <= out_st_nxt;
  end

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic       cfg_wr;
  logic [1:0] cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_idx    = cfg_paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_rows_r <= '0;
      num_cols_r <= '0;
      num_nnz_r  <= '0;
    end else if (cfg_wr) begin
      if (cfg_idx == REG_NUM_ROWS) num_rows_r <= cfg_pwdata[NROWS_W-1:0];
      if (cfg_idx == REG_NUM_COLS) num_cols_r <= cfg_pwdata[NCOLS_W-1:0];
      if (cfg_idx == REG_NUM_NNZ)  num_nnz_r  <= cfg_pwdata[NNZ_W-1:0];
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_NUM_ROWS: cfg_prdata = CFG_DW'(num_rows_r);
      REG_NUM_COLS: cfg_prdata = CFG_DW'(num_cols_r);
      REG_NUM_NNZ:  cfg_prdata = CFG_DW'(num_nnz_r);
      default:      cfg_prdata = '0;
    endcase
  end

endmodule

`default_nettype wire

[rtl/core/csr_tp_checker.sv]
// ----------------------------------------------------------------------------
// csr transpose port checker
// watches the streams of the transpose engine, bound to its top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "sparse_csr_transpose_assert.svh"

module csr_tp_checker
  import csr_tp_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  localparam int OUT_DW = ((POS_W + VALUE_WIDTH + 7) / 8) * 8
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              in_tvalid,
  input wire logic              in_tready,
  input wire logic [OP_W-1:0]   in_tuser,
  input wire logic              out_tvalid,
  input wire logic              out_tready,
  input wire logic [OUT_DW-1:0] out_tdata,
  input wire logic [ST_W-1:0]   out_tuser
);

  // a done transaction has gone out since reset
  logic seen_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_done_r <= 1'b0;
    end else if (out_tvalid && out_tready && (out_tuser == ST_DONE)) begin
      seen_done_r <= 1'b1;
    end
  end

  `CSRT_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `CSRT_ASSERT_NOW(a_ok_after_run, out_tvalid && (out_tuser == ST_OK), seen_done_r, "read ok before any run finished")
  `CSRT_ASSERT_NOW(a_zero_fields, out_tvalid && (out_tuser != ST_OK), out_tdata == '0, "non-ok result with nonzero fields")
  `CSRT_ASSERT_NEXT(a_run_busy, in_tvalid && in_tready && (in_tuser == OP_RUN), !in_tready, "input taken right after a run start")

endmodule

bind sparse_csr_transpose csr_tp_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_csr_tp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
